// File: hw/rtl/text_console_writer_macros.svh
`ifndef TEXT_CONSOLE_WRITER_MACROS_SVH
`define TEXT_CONSOLE_WRITER_MACROS_SVH

// Check that a condition implies another in the same cycle.
`define TCW_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Check that a condition implies another in the following cycle.
`define TCW_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: hw/rtl/tcw_pkg.sv
package tcw_pkg;

    // Default screen geometry
    localparam int COLUMNS_DEF   = 80;
    localparam int ROW_COUNT_DEF = 25;

    // Character and attribute codes
    localparam logic [7:0] NEWLINE_CODE = 8'd10;
    localparam logic [7:0] SPACE_CODE   = 8'h20;
    localparam logic [7:0] BLANK_ATTR   = 8'h0F;
    localparam logic [3:0] WHITE_FG     = 4'hF;
    localparam logic [7:0] ATTR_RESET   = 8'd15;

    typedef enum logic [2:0] {
        KIND_PUT       = 3'd0,
        KIND_MOVE      = 3'd1,
        KIND_SAVE_MOVE = 3'd2,
        KIND_RESTORE   = 3'd3,
        KIND_CLEAR     = 3'd4,
        KIND_READ      = 3'd5
    } kind_t;

    typedef enum logic [1:0] {
        ALU_CELL,
        ALU_BELOW,
        ALU_NEXT
    } alu_op_t;

    typedef enum logic [3:0] {
        ST_INIT,
        ST_IDLE,
        ST_PUT,
        ST_RD_ADDR,
        ST_RD_DATA,
        ST_FILL,
        ST_SC_RD,
        ST_SC_WR,
        ST_SC_BLANK,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic [2:0] kind;
        logic [7:0] char_code;
        logic [4:0] row;
        logic [6:0] col;
        logic [3:0] background;
    } in_item_t;

    typedef struct packed {
        logic [4:0] cursor_row;
        logic [6:0] cursor_col;
        logic [7:0] cell_char;
        logic [7:0] cell_attr;
    } out_item_t;

endpackage

// File: hw/rtl/tcw_ram.sv
module tcw_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 2000,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write one entry, read one entry with registered data
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// File: hw/rtl/tcw_alu.sv
module tcw_alu #(
    parameter int COLUMNS = 80,
    parameter int ADDR_W  = 11,
    parameter int COL_W   = 7
) (
    input  tcw_pkg::alu_op_t    op,
    input  logic [ADDR_W-1:0]   idx,
    input  logic [ADDR_W-1:0]   row_base,
    input  logic [COL_W-1:0]    col,
    output logic [ADDR_W-1:0]   sum
);

    import tcw_pkg::*;

    localparam logic [ADDR_W-1:0] COLUMNS_A = ADDR_W'(COLUMNS);

    logic [ADDR_W-1:0] opa;
    logic [ADDR_W-1:0] opb;

    // Select operands for the shared address adder
    always_comb
    begin
        unique case (op)
            ALU_CELL:
            begin
                opa = row_base;
                opb = ADDR_W'(col);
            end
            ALU_BELOW:
            begin
                opa = idx;
                opb = COLUMNS_A;
            end
            default:
            begin
                opa = idx;
                opb = ADDR_W'(1);
            end
        endcase
    end

    assign sum = opa + opb;

endmodule

// File: hw/rtl/tcw_ctrl.sv
module tcw_ctrl #(
    parameter int COLUMNS    = 80,
    parameter int ROW_COUNT  = 25,
    parameter int CELL_COUNT = ROW_COUNT * COLUMNS,
    parameter int ADDR_W     = $clog2(CELL_COUNT),
    parameter int ROW_W      = $clog2(ROW_COUNT),
    parameter int COL_W      = $clog2(COLUMNS)
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  tcw_pkg::in_item_t   in_data,
    output logic                out_valid,
    input  logic                out_ready,
    output tcw_pkg::out_item_t  out_data,
    input  logic                cfg_wr_en,
    input  logic [7:0]          cfg_wr_data,
    output tcw_pkg::alu_op_t    alu_op,
    output logic [ADDR_W-1:0]   alu_idx,
    output logic [ADDR_W-1:0]   alu_row_base,
    output logic [COL_W-1:0]    alu_col,
    input  logic [ADDR_W-1:0]   alu_sum,
    output logic                ram_we,
    output logic [ADDR_W-1:0]   ram_waddr,
    output logic [15:0]         ram_wdata,
    output logic [ADDR_W-1:0]   ram_raddr,
    input  logic [15:0]         ram_rdata
);

    import tcw_pkg::*;

    localparam logic [ROW_W-1:0]  LAST_ROW     = ROW_W'(ROW_COUNT - 1);
    localparam logic [COL_W-1:0]  LAST_COL     = COL_W'(COLUMNS - 1);
    localparam logic [ADDR_W-1:0] LAST_CELL    = ADDR_W'(CELL_COUNT - 1);
    localparam logic [ADDR_W-1:0] FIRST_BOTTOM = ADDR_W'(CELL_COUNT - COLUMNS);
    localparam logic [ADDR_W-1:0] COLUMNS_A    = ADDR_W'(COLUMNS);

    state_t            state_reg,     state_next;
    logic [ADDR_W-1:0] idx_reg,       idx_next;
    logic [ROW_W-1:0]  cur_row_reg,   cur_row_next;
    logic [COL_W-1:0]  cur_col_reg,   cur_col_next;
    logic [ROW_W-1:0]  sav_row_reg,   sav_row_next;
    logic [COL_W-1:0]  sav_col_reg,   sav_col_next;
    logic [7:0]        attr_reg;
    logic              out_valid_reg, out_valid_next;
    logic [ADDR_W-1:0] row_base_reg,  row_base_next;
    logic [COL_W-1:0]  addr_col_reg,  addr_col_next;
    logic [7:0]        char_reg,      char_next;
    logic [2:0]        kind_reg,      kind_next;
    logic [15:0]       fill_reg,      fill_next;
    logic [15:0]       rd_cell_reg,   rd_cell_next;
    out_item_t         out_data_reg,  out_data_next;

    logic [ROW_W-1:0]  tgt_row;
    logic [COL_W-1:0]  tgt_col;
    logic [ROW_W+4:0]  row_ext;
    logic [COL_W+6:0]  col_ext;

    // Saturate cursor targets to the screen
    always_comb
    begin
        if (int'(in_data.row) > ROW_COUNT - 1)
        begin
            tgt_row = LAST_ROW;
        end
        else
        begin
            tgt_row = ROW_W'(in_data.row);
        end
        if (int'(in_data.col) > COLUMNS - 1)
        begin
            tgt_col = LAST_COL;
        end
        else
        begin
            tgt_col = COL_W'(in_data.col);
        end
    end

    assign row_ext = (ROW_W + 5)'(cur_row_reg);
    assign col_ext = (COL_W + 7)'(cur_col_reg);

    assign alu_idx      = idx_reg;
    assign alu_row_base = row_base_reg;
    assign alu_col      = addr_col_reg;
    assign in_ready     = (state_reg == ST_IDLE);
    assign out_valid    = out_valid_reg;
    assign out_data     = out_data_reg;

    // Hold the state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_INIT;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Hold cursor, index, attribute and output control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg       <= '0;
            cur_row_reg   <= '0;
            cur_col_reg   <= '0;
            sav_row_reg   <= '0;
            sav_col_reg   <= '0;
            attr_reg      <= ATTR_RESET;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            idx_reg       <= idx_next;
            cur_row_reg   <= cur_row_next;
            cur_col_reg   <= cur_col_next;
            sav_row_reg   <= sav_row_next;
            sav_col_reg   <= sav_col_next;
            out_valid_reg <= out_valid_next;
            if (cfg_wr_en)
            begin
                attr_reg <= cfg_wr_data;
            end
        end
    end

    // Hold item payload
    always_ff @(posedge clk)
    begin
        row_base_reg <= row_base_next;
        addr_col_reg <= addr_col_next;
        char_reg     <= char_next;
        kind_reg     <= kind_next;
        fill_reg     <= fill_next;
        rd_cell_reg  <= rd_cell_next;
        out_data_reg <= out_data_next;
    end

    // Sequence each item through the shared adder and the cell store
    always_comb
    begin
        state_next     = state_reg;
        idx_next       = idx_reg;
        cur_row_next   = cur_row_reg;
        cur_col_next   = cur_col_reg;
        sav_row_next   = sav_row_reg;
        sav_col_next   = sav_col_reg;
        out_valid_next = out_valid_reg;
        row_base_next  = row_base_reg;
        addr_col_next  = addr_col_reg;
        char_next      = char_reg;
        kind_next      = kind_reg;
        fill_next      = fill_reg;
        rd_cell_next   = rd_cell_reg;
        out_data_next  = out_data_reg;
        alu_op         = ALU_NEXT;
        ram_we         = 1'b0;
        ram_waddr      = idx_reg;
        ram_wdata      = fill_reg;
        ram_raddr      = alu_sum;

        // Drop the held result once taken
        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_INIT:
            begin
                ram_we    = 1'b1;
                ram_wdata = '0;
                if (idx_reg == LAST_CELL)
                begin
                    idx_next   = '0;
                    state_next = ST_IDLE;
                end
                else
                begin
                    idx_next = alu_sum;
                end
            end
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    kind_next  = in_data.kind;
                    char_next  = in_data.char_code;
                    state_next = ST_DONE;
                    unique case (kind_t'(in_data.kind))
                        KIND_PUT:
                        begin
                            if (in_data.char_code == NEWLINE_CODE)
                            begin
                                cur_col_next = '0;
                                if (cur_row_reg == LAST_ROW)
                                begin
                                    idx_next   = '0;
                                    state_next = ST_SC_RD;
                                end
                                else
                                begin
                                    cur_row_next = cur_row_reg + ROW_W'(1);
                                end
                            end
                            else
                            begin
                                row_base_next = ADDR_W'(ADDR_W'(cur_row_reg) * COLUMNS_A);
                                addr_col_next = cur_col_reg;
                                state_next    = ST_PUT;
                            end
                        end
                        KIND_MOVE:
                        begin
                            cur_row_next = tgt_row;
                            cur_col_next = tgt_col;
                        end
                        KIND_SAVE_MOVE:
                        begin
                            sav_row_next = cur_row_reg;
                            sav_col_next = cur_col_reg;
                            cur_row_next = tgt_row;
                            cur_col_next = tgt_col;
                        end
                        KIND_RESTORE:
                        begin
                            cur_row_next = sav_row_reg;
                            cur_col_next = sav_col_reg;
                        end
                        KIND_CLEAR:
                        begin
                            fill_next  = {in_data.background, WHITE_FG, SPACE_CODE};
                            idx_next   = '0;
                            state_next = ST_FILL;
                        end
                        KIND_READ:
                        begin
                            row_base_next = ADDR_W'(ADDR_W'(tgt_row) * COLUMNS_A);
                            addr_col_next = tgt_col;
                            state_next    = ST_RD_ADDR;
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            ST_PUT:
            begin
                alu_op    = ALU_CELL;
                ram_we    = 1'b1;
                ram_waddr = alu_sum;
                ram_wdata = {attr_reg, char_reg};
                state_next = ST_DONE;
                if (cur_col_reg == LAST_COL)
                begin
                    cur_col_next = '0;
                    if (cur_row_reg == LAST_ROW)
                    begin
                        idx_next   = '0;
                        state_next = ST_SC_RD;
                    end
                    else
                    begin
                        cur_row_next = cur_row_reg + ROW_W'(1);
                    end
                end
                else
                begin
                    cur_col_next = cur_col_reg + COL_W'(1);
                end
            end
            ST_RD_ADDR:
            begin
                alu_op     = ALU_CELL;
                ram_raddr  = alu_sum;
                state_next = ST_RD_DATA;
            end
            ST_RD_DATA:
            begin
                rd_cell_next = ram_rdata;
                state_next   = ST_DONE;
            end
            ST_FILL:
            begin
                ram_we = 1'b1;
                if (idx_reg == LAST_CELL)
                begin
                    state_next = ST_DONE;
                end
                else
                begin
                    idx_next = alu_sum;
                end
            end
            ST_SC_RD:
            begin
                if (idx_reg == FIRST_BOTTOM)
                begin
                    state_next = ST_SC_BLANK;
                end
                else
                begin
                    alu_op     = ALU_BELOW;
                    ram_raddr  = alu_sum;
                    state_next = ST_SC_WR;
                end
            end
            ST_SC_WR:
            begin
                ram_we     = 1'b1;
                ram_wdata  = ram_rdata;
                idx_next   = alu_sum;
                state_next = ST_SC_RD;
            end
            ST_SC_BLANK:
            begin
                ram_we    = 1'b1;
                ram_wdata = {BLANK_ATTR, SPACE_CODE};
                if (idx_reg == LAST_CELL)
                begin
                    state_next = ST_DONE;
                end
                else
                begin
                    idx_next = alu_sum;
                end
            end
            ST_DONE:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next           = 1'b1;
                    out_data_next.cursor_row = row_ext[4:0];
                    out_data_next.cursor_col = col_ext[6:0];
                    if (kind_reg == KIND_READ)
                    begin
                        out_data_next.cell_char = rd_cell_reg[7:0];
                        out_data_next.cell_attr = rd_cell_reg[15:8];
                    end
                    else
                    begin
                        out_data_next.cell_char = '0;
                        out_data_next.cell_attr = '0;
                    end
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    `include "text_console_writer_macros.svh"

    `TCW_ASSERT_NEXT(a_busy_after_accept, clk, rst_n, in_valid && in_ready, !in_ready, "ready after accept")
    `TCW_ASSERT_NOW(a_no_write_idle, clk, rst_n, ram_we, !in_ready, "store written while idle")
    `TCW_ASSERT_NEXT(a_result_loaded, clk, rst_n, (state_reg == ST_DONE) && (!out_valid_reg || out_ready), out_valid_reg, "result not loaded")
    `TCW_ASSERT_NOW(a_cursor_range, clk, rst_n, 1'b1, (cur_row_reg <= LAST_ROW) && (cur_col_reg <= LAST_COL), "cursor off screen")

endmodule

// File: hw/rtl/text_console_writer.sv
// Each item goes from idle to the done state, which loads the result once the previous is taken.
// Moves, save, restore and unused kinds go straight to done; a put character writes one cell;
// a cell read forms the address, then captures the registered data; a clear screen fills every
// cell; a scroll copies each cell from the row below via the shared adder, then blanks the bottom
// row. One item at a time; ready is low meanwhile. Reset clears cursors and sets the attribute to
// 0x0F, then sweeps the store to zero with in_ready low; config writes are taken throughout.
module text_console_writer #(
    parameter int COLUMNS   = tcw_pkg::COLUMNS_DEF,
    parameter int ROW_COUNT = tcw_pkg::ROW_COUNT_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  tcw_pkg::in_item_t   in_data,
    output logic                out_valid,
    input  logic                out_ready,
    output tcw_pkg::out_item_t  out_data,
    input  logic                cfg_wr_en,
    input  logic [7:0]          cfg_wr_data
);

    import tcw_pkg::*;

    localparam int CELL_COUNT = ROW_COUNT * COLUMNS;
    localparam int ADDR_W     = $clog2(CELL_COUNT);
    localparam int ROW_W      = $clog2(ROW_COUNT);
    localparam int COL_W      = $clog2(COLUMNS);

    alu_op_t           alu_op;
    logic [ADDR_W-1:0] alu_idx;
    logic [ADDR_W-1:0] alu_row_base;
    logic [COL_W-1:0]  alu_col;
    logic [ADDR_W-1:0] alu_sum;
    logic              ram_we;
    logic [ADDR_W-1:0] ram_waddr;
    logic [15:0]       ram_wdata;
    logic [ADDR_W-1:0] ram_raddr;
    logic [15:0]       ram_rdata;

    // Sequencer with cursor and output register
    tcw_ctrl #(
        .COLUMNS    (COLUMNS),
        .ROW_COUNT  (ROW_COUNT),
        .CELL_COUNT (CELL_COUNT),
        .ADDR_W     (ADDR_W),
        .ROW_W      (ROW_W),
        .COL_W      (COL_W)
    ) u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .in_data      (in_data),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .out_data     (out_data),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_data  (cfg_wr_data),
        .alu_op       (alu_op),
        .alu_idx      (alu_idx),
        .alu_row_base (alu_row_base),
        .alu_col      (alu_col),
        .alu_sum      (alu_sum),
        .ram_we       (ram_we),
        .ram_waddr    (ram_waddr),
        .ram_wdata    (ram_wdata),
        .ram_raddr    (ram_raddr),
        .ram_rdata    (ram_rdata)
    );

    // Shared address adder
    tcw_alu #(
        .COLUMNS (COLUMNS),
        .ADDR_W  (ADDR_W),
        .COL_W   (COL_W)
    ) u_alu (
        .op       (alu_op),
        .idx      (alu_idx),
        .row_base (alu_row_base),
        .col      (alu_col),
        .sum      (alu_sum)
    );

    // Character and attribute cell store
    tcw_ram #(
        .WIDTH (16),
        .DEPTH (CELL_COUNT),
        .AW    (ADDR_W)
    ) u_cells (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

endmodule
